// ----- rtl/core/b64w_pkg.sv -----
// Shared types, constants and the symbol table for the base64 line-wrap encoder.
`default_nettype none
package b64w_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned JobSlots = 6;
  localparam int unsigned SlotW    = 3;

  localparam logic [7:0] NewlineChar = 8'd10;
  localparam logic [7:0] TabChar     = 8'd9;
  localparam logic [7:0] PadChar     = 8'd61;

  // One queued job: the characters caused by one input word, in order.
  typedef struct packed {
    logic [JobSlots-1:0][7:0] chars;
    logic [SlotW-1:0]         num;
    logic                     fin;
  } job_t;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/base64_encoder_line_wrap_unit.sv -----
// Top level of the base64 encoder with optional newline-tab line wrapping.
// Bytes enter one per word on the input channel; each accepted byte is turned
// into zero to six characters at once, and a job holding any characters is
// placed in a job queue of QueueDepth entries, so the input side takes a new
// byte in every cycle while the queue has room. The output side delivers one
// character per cycle from a registered stage while out_ready is high and the
// queue holds a job, so the sustained rate is set by the characters per byte.
// The first character of a job is loaded from the queue head into the output
// register once the output register is free. A byte that only completes part
// of a group and neither opens a message with wrapping on nor ends one adds
// nothing to the output.
// wrap_width is written through cfg_we/cfg_wdata and must only change while
// the block is idle.
`default_nettype none
module base64_encoder_line_wrap_unit #(
  parameter int unsigned QueueDepth = b64w_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             end_of_run,
  output logic             end_of_message
);
  import b64w_pkg::*;

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  b64w_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  b64w_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64w_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message)
  );

endmodule
`default_nettype wire

// ----- rtl/core/b64w_front.sv -----
// Front end: accepts bytes, tracks group and column state, and builds one job per word.
`default_nettype none
module b64w_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                final_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output b64w_pkg::job_t           q_job
);
  import b64w_pkg::*;

  logic [15:0] wrap_width;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [1:0]  group_fill;
  logic [16:0] column_count;
  logic        mid_message;

  logic [1:0]  eff_fill;
  logic [1:0]  fill_after;
  logic        pre;
  logic        grp;
  logic        do_pad;
  logic        wrap_on;
  logic        wrap_hit;
  logic        accept;
  logic [16:0] col_base;
  logic [16:0] col_sum;
  logic [16:0] column_next;
  logic [7:0]  s0, s1, s2, s3;
  logic [7:0]  p0, p1, p2, p3;
  logic [3:0]  p1_low;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign wrap_on  = (wrap_width != 16'd0);
  assign eff_fill = mid_message ? group_fill : 2'd0;
  assign pre      = !mid_message && wrap_on;
  assign grp      = eff_fill[1];

  always_comb begin
    case (eff_fill)
      2'd0:    fill_after = 2'd1;
      2'd1:    fill_after = 2'd2;
      default: fill_after = 2'd0;
    endcase
  end

  assign do_pad = final_byte && (fill_after != 2'd0);

  assign col_base = mid_message ? column_count : 17'd0;
  assign col_sum  = col_base + 17'd4;
  assign wrap_hit = grp && wrap_on && (col_sum > {1'b0, wrap_width});

  always_comb begin
    if (final_byte) begin
      column_next = '0;
    end else if (grp) begin
      column_next = (!wrap_on || wrap_hit) ? 17'd0 : col_sum;
    end else begin
      column_next = col_base;
    end
  end

  // Full group symbols: two held bytes plus the incoming one.
  assign s0 = b64_symbol(held0[7:2]);
  assign s1 = b64_symbol({held0[1:0], held1[7:4]});
  assign s2 = b64_symbol({held1[3:0], data_byte[7:6]});
  assign s3 = b64_symbol(data_byte[5:0]);

  // Padded tail: with one byte in the group it is the incoming byte, with two
  // it is the held byte followed by the incoming one.
  always_comb begin
    if (fill_after == 2'd2) begin
      p0     = b64_symbol(held0[7:2]);
      p1_low = data_byte[7:4];
      p1     = b64_symbol({held0[1:0], p1_low});
      p2     = b64_symbol({data_byte[3:0], 2'b00});
    end else begin
      p0     = b64_symbol(data_byte[7:2]);
      p1_low = 4'd0;
      p1     = b64_symbol({data_byte[1:0], p1_low});
      p2     = PadChar;
    end
    p3 = PadChar;
  end

  always_comb begin
    q_job.fin = final_byte;
    if (grp) begin
      q_job.chars[0] = s0;
      q_job.chars[1] = s1;
      q_job.chars[2] = s2;
      q_job.chars[3] = s3;
      q_job.chars[4] = NewlineChar;
      q_job.chars[5] = TabChar;
      q_job.num      = wrap_hit ? SlotW'(6) : SlotW'(4);
    end else if (pre) begin
      q_job.chars[0] = NewlineChar;
      q_job.chars[1] = TabChar;
      q_job.chars[2] = p0;
      q_job.chars[3] = p1;
      q_job.chars[4] = p2;
      q_job.chars[5] = p3;
      q_job.num      = do_pad ? SlotW'(6) : SlotW'(2);
    end else begin
      q_job.chars[0] = p0;
      q_job.chars[1] = p1;
      q_job.chars[2] = p2;
      q_job.chars[3] = p3;
      q_job.chars[4] = NewlineChar;
      q_job.chars[5] = TabChar;
      q_job.num      = do_pad ? SlotW'(4) : SlotW'(0);
    end
  end

  assign q_push = accept && (q_job.num != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= '0;
    end else if (cfg_we) begin
      wrap_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held0        <= '0;
      held1        <= '0;
      group_fill   <= '0;
      column_count <= '0;
      mid_message  <= 1'b0;
    end else if (accept) begin
      column_count <= column_next;
      mid_message  <= !final_byte;
      group_fill   <= final_byte ? 2'd0 : fill_after;
      if (final_byte) begin
        held0 <= '0;
        held1 <= '0;
      end else if (eff_fill == 2'd0) begin
        held0 <= data_byte;
      end else if (eff_fill == 2'd1) begin
        held1 <= data_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/b64w_queue.sv -----
// Small job queue between the front end and the character serializer.
`default_nettype none
module b64w_queue #(
  parameter int unsigned Depth = b64w_pkg::QueueDepthDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64w_pkg::job_t wr_job,
  input  wire logic           pop,
  output b64w_pkg::job_t      rd_job,
  output logic                full,
  output logic                empty
);
  import b64w_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full   = (count == CntW'(Depth));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CntW'(Depth))
    else $error("job queue count out of range");
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_job.num != '0) && (wr_job.num <= SlotW'(JobSlots)))
    else $error("job queue given a job with a bad character count");

endmodule
`default_nettype wire

// ----- rtl/core/b64w_back.sv -----
// Back end: walks the head job one character per cycle into the output register while out_ready allows.
`default_nettype none
module b64w_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire b64w_pkg::job_t head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_char,
  output logic                end_of_run,
  output logic                end_of_message
);
  import b64w_pkg::*;

  logic [SlotW-1:0] idx;
  logic             load;
  logic             last;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign last  = (idx == head.num - 1'b1);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char       <= head.chars[idx];
      end_of_run     <= last;
      end_of_message <= last && head.fin;
    end
  end

endmodule
`default_nettype wire

// ----- verif/b64w_stream_checker.sv -----
// Watches the encoder's channels, predicts each character and compares it in order.
module b64w_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_char,
  input  logic        end_of_run,
  input  logic        end_of_message,
  output int          error_count,
  output int          pending_chars
);

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } enc_char_t;

  enc_char_t   expected_chars[$];

  // Encoder state as the predictor sees it.
  logic [15:0] width_seen;
  logic [7:0]  held_bytes[2];
  logic [1:0]  group_fill;
  logic [16:0] column_count;
  logic        in_message;

  // Characters caused by the byte being predicted.
  logic [7:0]  run_chars[6];
  int          run_len;
  int          words_seen;

  initial begin
    error_count   = 0;
    pending_chars = 0;
    words_seen    = 0;
  end

  function automatic logic [7:0] symbol_of(input logic [5:0] v);
    return Alphabet[8*(63 - int'(v)) +: 8];
  endfunction

  task automatic append_char(input logic [7:0] ch);
    run_chars[run_len] = ch;
    run_len++;
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at output word %0d: %s", words_seen, what);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    enc_char_t  item;
    b0 = held_bytes[0];
    b1 = held_bytes[1];
    run_len = 0;
    if (!in_message) begin
      in_message   = 1'b1;
      column_count = '0;
      group_fill   = '0;
      if (width_seen != 16'd0) begin
        append_char(b64w_pkg::NewlineChar);
        append_char(b64w_pkg::TabChar);
      end
    end
    if (group_fill == 2'd0) begin
      held_bytes[0] = b;
      group_fill    = 2'd1;
    end else if (group_fill == 2'd1) begin
      held_bytes[1] = b;
      group_fill    = 2'd2;
    end else begin
      append_char(symbol_of(b0[7:2]));
      append_char(symbol_of({b0[1:0], b1[7:4]}));
      append_char(symbol_of({b1[3:0], b[7:6]}));
      append_char(symbol_of(b[5:0]));
      group_fill = 2'd0;
      if (width_seen == 16'd0) begin
        column_count = '0;
      end else begin
        column_count = column_count + 17'd4;
        if (column_count > {1'b0, width_seen}) begin
          column_count = '0;
          append_char(b64w_pkg::NewlineChar);
          append_char(b64w_pkg::TabChar);
        end
      end
    end
    if (fin) begin
      // A partial group is flushed with padding.
      if (group_fill == 2'd1) begin
        append_char(symbol_of(held_bytes[0][7:2]));
        append_char(symbol_of({held_bytes[0][1:0], 4'b0000}));
        append_char(b64w_pkg::PadChar);
        append_char(b64w_pkg::PadChar);
      end else if (group_fill == 2'd2) begin
        append_char(symbol_of(held_bytes[0][7:2]));
        append_char(symbol_of({held_bytes[0][1:0], held_bytes[1][7:4]}));
        append_char(symbol_of({held_bytes[1][3:0], 2'b00}));
        append_char(b64w_pkg::PadChar);
      end
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      group_fill    = '0;
      column_count  = '0;
      in_message    = 1'b0;
    end
    for (int k = 0; k < run_len; k++) begin
      item.ch      = run_chars[k];
      item.run_end = (k == run_len - 1);
      item.msg_end = (k == run_len - 1) && fin;
      expected_chars.insert(expected_chars.size(), item);
    end
  endtask

  task automatic check_char();
    enc_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected character 0x%02h", out_char));
    end else begin
      want = expected_chars.pop_front();
      if (out_char !== want.ch) begin
        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", out_char, want.ch));
      end
      if (end_of_run !== want.run_end) begin
        report_mismatch($sformatf("end_of_run %b, expected %b", end_of_run, want.run_end));
      end
      if (end_of_message !== want.msg_end) begin
        report_mismatch($sformatf("end_of_message %b, expected %b", end_of_message,
                                  want.msg_end));
      end
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_seen    = '0;
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      group_fill    = '0;
      column_count  = '0;
      in_message    = 1'b0;
      expected_chars.delete();
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(data_byte, final_byte);
      end
      if (out_valid && out_ready) begin
        check_char();
      end
      if (cfg_we) begin
        width_seen = cfg_wdata;
      end
    end
    pending_chars = expected_chars.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Stimulus, clock, reset and verdict for the base64 line-wrap encoder.
module tb_top;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 32;
  localparam int PhaseWords   = 45;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic [7:0]  data_byte  = '0;
  logic        final_byte = 1'b0;
  logic        out_ready  = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        end_of_run;
  logic        end_of_message;

  int          error_count;
  int          pending_chars;
  int          cycle_count;

  logic        in_gaps_on    = 1'b1;
  logic        out_stalls_on = 1'b1;

  base64_encoder_line_wrap_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .final_byte     (final_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message)
  );

  b64w_stream_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .final_byte     (final_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message),
    .error_count    (error_count),
    .pending_chars  (pending_chars)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshakes are judged at the falling edge, where every signal is settled.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int  gap;
    logic took;
    gap = in_gaps_on ? $urandom_range(17, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_message(input int len, input logic close_it);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255, 0)), close_it && (i == len - 1));
    end
  endtask

  // Bytes that complete no character may still be in flight once the last
  // expected character is out, hence the settle time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_chars != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_wrap_width(input logic [15:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int   stall;
    logic took;
    @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(17, 0) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [15:0] widths[10];
    int          remaining;
    int          len;
    logic        leave_open;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wrapping off after reset: one-byte, two-byte and full-group messages.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'hfd, 1'b1);
    wait_idle();

    // Width 4 wraps after the second group; the last byte is padded.
    set_wrap_width(16'd4);
    for (int i = 0; i < 7; i++) begin
      send_byte(i % 3 == 0 ? 8'h4d : (i % 3 == 1 ? 8'h61 : 8'h6e), i == 6);
    end
    wait_idle();

    // Width 1 wraps after every group, including the one that ends the message.
    set_wrap_width(16'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h51, 1'b0);
    send_byte(8'h87, 1'b1);
    wait_idle();

    // The width changes while a message is open.
    set_wrap_width(16'hffff);
    send_byte(8'haa, 1'b0);
    send_byte(8'hbb, 1'b0);
    send_byte(8'hcc, 1'b0);
    send_byte(8'hdd, 1'b0);
    wait_idle();
    set_wrap_width(16'd8);
    send_byte(8'hee, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_idle();

    widths = '{16'd1, 16'd4, 16'd0, 16'd2, 16'hffff, 16'($urandom_range(24, 3)), 16'd5,
               16'($urandom_range(65535, 0)), 16'd3, 16'($urandom_range(40, 6))};
    for (int phase = 0; phase < 10; phase++) begin
      set_wrap_width(widths[phase]);
      in_gaps_on    <= (phase % 4 == 0) || (phase % 4 == 2);
      out_stalls_on <= (phase % 4 == 0) || (phase % 4 == 3);
      leave_open = (phase % 3 == 2);
      remaining  = PhaseWords;
      while (remaining > 0) begin
        len = ($urandom_range(3, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
        if (len >= remaining) begin
          send_message(remaining, !leave_open);
          remaining = 0;
        end else begin
          send_message(len, 1'b1);
          remaining -= len;
        end
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
